// ===== hw/rtl/tftp_transfer_engine_defines.svh =====
// Assertion macros shared by the transfer engine RTL.
`ifndef TFTP_TRANSFER_ENGINE_DEFINES_SVH
`define TFTP_TRANSFER_ENGINE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TTE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tte_pkg.sv =====
// Package with codes, request and result types of the transfer engine.
`default_nettype none
package tte_pkg;

    localparam int BLOCK_BYTES_DEF = 512;
    localparam int LEN_MAX         = 1023;
    localparam logic [9:0] HDR_BYTES = 10'd4;
    localparam logic [3:0] RETRY_LIMIT_RST = 4'd5;

    typedef enum logic [1:0] {
        EV_PACKET  = 2'd0,
        EV_TIMEOUT = 2'd1,
        EV_CHUNK   = 2'd2,
        EV_FAULT   = 2'd3
    } event_t;

    localparam logic [15:0] OPC_RRQ   = 16'd1;
    localparam logic [15:0] OPC_WRQ   = 16'd2;
    localparam logic [15:0] OPC_DATA  = 16'd3;
    localparam logic [15:0] OPC_ACK   = 16'd4;
    localparam logic [15:0] OPC_ERROR = 16'd5;

    typedef enum logic [2:0] {
        ACT_DATA  = 3'd0,
        ACT_ACK   = 3'd1,
        ACT_ERROR = 3'd2,
        ACT_FETCH = 3'd3,
        ACT_STORE = 3'd4,
        ACT_DONE  = 3'd5,
        ACT_ABORT = 3'd6
    } action_t;

    localparam logic [2:0] WHY_NONE     = 3'd0;
    localparam logic [2:0] WHY_SIZE     = 3'd0;
    localparam logic [2:0] WHY_OPCODE   = 3'd1;
    localparam logic [2:0] WHY_UNEXPECT = 3'd2;
    localparam logic [2:0] WHY_ACK_NUM  = 3'd3;
    localparam logic [2:0] WHY_BLK_NUM  = 3'd4;

    localparam logic [2:0] CAUSE_NONE    = 3'd0;
    localparam logic [2:0] CAUSE_PEER    = 3'd1;
    localparam logic [2:0] CAUSE_TIMEOUT = 3'd2;
    localparam logic [2:0] CAUSE_LINK    = 3'd3;
    localparam logic [2:0] CAUSE_PROTO   = 3'd4;

    typedef struct packed {
        logic [9:0]  chunk_len;
        logic [15:0] pkt_block;
        logic [15:0] pkt_opcode;
        logic [9:0]  pkt_size;
        event_t      op;
    } req_t;

    typedef struct packed {
        action_t     action;
        logic [2:0]  abort_cause;
        logic [2:0]  error_reason;
        logic [9:0]  byte_count;
        logic [15:0] block_no;
    } res_t;

    function automatic res_t mk_res(action_t act, logic [15:0] blk, logic [9:0] cnt,
                                    logic [2:0] why, logic [2:0] cause);
        res_t r;
        r.action       = act;
        r.block_no     = blk;
        r.byte_count   = cnt;
        r.error_reason = why;
        r.abort_cause  = cause;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/tftp_transfer_engine.sv =====
// Top level of the lock-step TFTP server transfer engine.
//
//  Channel   Direction  Handshake            Payload
//  s_        in         s_tvalid/s_tready    s_tdata: one event request
//  m_        out        m_tvalid/m_tready    m_tuser: action, m_tdata, m_tlast
//  cfg_      in         cfg_wr_en            cfg_wr_data: retry limit
//
// A request is taken into an input register and decoded once the result queue can take
// its zero to three actions, which are loaded into the three-entry queue in one step.
// Requests are accepted every cycle while m_tready is high; a request with more than one
// action holds the input side until its last action pops; the queue drains one per cycle.
// The input register is free to take a request while the queue still waits on m_tready.
// Synchronous active-low reset returns the engine to idle with the retry limit at five.
`default_nettype none
`include "tftp_transfer_engine_defines.svh"
module tftp_transfer_engine
    import tte_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [3:0]  cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // op[1:0], pkt_size[11:2], pkt_opcode[27:12], pkt_block[43:28], chunk_len[53:44]
    input  wire logic [55:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // block_no[15:0], byte_count[25:16], error_reason[28:26], abort_cause[31:29]
    output logic [31:0]      m_tdata,
    // action[2:0]
    output logic [2:0]       m_tuser,
    output logic             m_tlast
);

    localparam int LenCap = (BLOCK_BYTES > LEN_MAX) ? LEN_MAX : BLOCK_BYTES;
    localparam logic [9:0]  LenCapV  = 10'(LenCap);
    localparam logic [10:0] BlockLen = 11'(BLOCK_BYTES);

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_RD_FETCH = 2'd1,
        MODE_RD_ACK   = 2'd2,
        MODE_WRITE    = 2'd3
    } mode_t;

    logic        in_valid_reg;
    req_t        in_reg;
    logic [3:0]  retry_limit_reg;
    mode_t       mode_reg, mode_next;
    logic [15:0] block_reg, block_next;
    logic [3:0]  retries_reg, retries_next;
    logic        final_reg, final_next;
    logic [9:0]  length_reg, length_next;
    res_t        queue_reg [3];
    logic [1:0]  count_reg;

    res_t        ld_res [3];
    logic [1:0]  ld_n;
    logic        load;
    logic        pop;
    logic [3:0]  budget;
    logic [15:0] blk_inc;
    logic [9:0]  clen_cl;
    logic [9:0]  plen_cl;
    logic [9:0]  plen_raw;

    assign pop      = m_tvalid && m_tready;
    assign load     = in_valid_reg && ((count_reg == 2'd0) || ((count_reg == 2'd1) && pop));
    assign s_tready = !in_valid_reg || load;
    assign m_tvalid = (count_reg != 2'd0);
    assign m_tuser  = queue_reg[0].action;
    assign m_tdata  = {queue_reg[0].abort_cause, queue_reg[0].error_reason,
                       queue_reg[0].byte_count, queue_reg[0].block_no};
    assign m_tlast  = (count_reg == 2'd1);

    assign budget   = (retry_limit_reg == 4'd0) ? 4'd1 : retry_limit_reg;
    assign blk_inc  = block_reg + 16'd1;
    assign clen_cl  = (in_reg.chunk_len > LenCapV) ? LenCapV : in_reg.chunk_len;
    assign plen_raw = in_reg.pkt_size - HDR_BYTES;
    assign plen_cl  = (plen_raw > LenCapV) ? LenCapV : plen_raw;

    always_comb begin
        mode_next    = mode_reg;
        block_next   = block_reg;
        retries_next = retries_reg;
        final_next   = final_reg;
        length_next  = length_reg;
        ld_n         = 2'd0;
        for (int i = 0; i < 3; i++) begin
            ld_res[i] = mk_res(ACT_DATA, 16'd0, 10'd0, WHY_NONE, CAUSE_NONE);
        end
        if (mode_reg == MODE_IDLE) begin
            if (in_reg.op == EV_PACKET) begin
                ld_n = 2'd1;
                if (in_reg.pkt_size < HDR_BYTES) begin
                    ld_res[0] = mk_res(ACT_ERROR, 16'd0, 10'd0, WHY_SIZE, CAUSE_NONE);
                end else if (in_reg.pkt_opcode == OPC_RRQ) begin
                    block_next  = 16'd0;
                    final_next  = 1'b0;
                    length_next = 10'd0;
                    mode_next   = MODE_RD_FETCH;
                    ld_res[0]   = mk_res(ACT_FETCH, 16'd1, 10'd0, WHY_NONE, CAUSE_NONE);
                end else if (in_reg.pkt_opcode == OPC_WRQ) begin
                    block_next   = 16'd0;
                    final_next   = 1'b0;
                    length_next  = 10'd0;
                    retries_next = budget;
                    mode_next    = MODE_WRITE;
                    ld_res[0]    = mk_res(ACT_ACK, 16'd0, 10'd0, WHY_NONE, CAUSE_NONE);
                end else begin
                    ld_res[0] = mk_res(ACT_ERROR, 16'd0, 10'd0, WHY_OPCODE, CAUSE_NONE);
                end
            end
        end else if (in_reg.op == EV_FAULT) begin
            ld_n      = 2'd1;
            mode_next = MODE_IDLE;
            ld_res[0] = mk_res(ACT_ABORT, 16'd0, 10'd0, WHY_NONE, CAUSE_LINK);
        end else if (mode_reg == MODE_RD_FETCH) begin
            if (in_reg.op == EV_CHUNK) begin
                ld_n         = 2'd1;
                block_next   = blk_inc;
                final_next   = ({1'b0, clen_cl} < BlockLen);
                length_next  = clen_cl;
                retries_next = budget;
                mode_next    = MODE_RD_ACK;
                ld_res[0]    = mk_res(ACT_DATA, blk_inc, clen_cl, WHY_NONE, CAUSE_NONE);
            end
        end else if (in_reg.op == EV_TIMEOUT) begin
            ld_n         = 2'd1;
            retries_next = retries_reg - 4'd1;
            if (retries_next == 4'd0) begin
                mode_next = MODE_IDLE;
                ld_res[0] = mk_res(ACT_ABORT, 16'd0, 10'd0, WHY_NONE, CAUSE_TIMEOUT);
            end else if (mode_reg == MODE_RD_ACK) begin
                ld_res[0] = mk_res(ACT_DATA, block_reg, length_reg, WHY_NONE, CAUSE_NONE);
            end else begin
                ld_res[0] = mk_res(ACT_ACK, block_reg, 10'd0, WHY_NONE, CAUSE_NONE);
            end
        end else if (in_reg.op == EV_PACKET) begin
            if (in_reg.pkt_size < HDR_BYTES) begin
                ld_n      = 2'd2;
                mode_next = MODE_IDLE;
                ld_res[0] = mk_res(ACT_ERROR, 16'd0, 10'd0, WHY_SIZE, CAUSE_NONE);
                ld_res[1] = mk_res(ACT_ABORT, 16'd0, 10'd0, WHY_NONE, CAUSE_PROTO);
            end else if (in_reg.pkt_opcode == OPC_ERROR) begin
                ld_n      = 2'd1;
                mode_next = MODE_IDLE;
                ld_res[0] = mk_res(ACT_ABORT, 16'd0, 10'd0, WHY_NONE, CAUSE_PEER);
            end else if (mode_reg == MODE_RD_ACK) begin
                if (in_reg.pkt_opcode != OPC_ACK || in_reg.pkt_block != block_reg) begin
                    ld_n      = 2'd2;
                    mode_next = MODE_IDLE;
                    ld_res[0] = mk_res(ACT_ERROR, 16'd0, 10'd0,
                                       (in_reg.pkt_opcode != OPC_ACK) ? WHY_UNEXPECT
                                                                      : WHY_ACK_NUM,
                                       CAUSE_NONE);
                    ld_res[1] = mk_res(ACT_ABORT, 16'd0, 10'd0, WHY_NONE, CAUSE_PROTO);
                end else if (final_reg) begin
                    ld_n      = 2'd1;
                    mode_next = MODE_IDLE;
                    ld_res[0] = mk_res(ACT_DONE, block_reg, 10'd0, WHY_NONE, CAUSE_NONE);
                end else begin
                    ld_n      = 2'd1;
                    mode_next = MODE_RD_FETCH;
                    ld_res[0] = mk_res(ACT_FETCH, blk_inc, 10'd0, WHY_NONE, CAUSE_NONE);
                end
            end else begin
                if (in_reg.pkt_opcode != OPC_DATA || in_reg.pkt_block != blk_inc) begin
                    ld_n      = 2'd2;
                    mode_next = MODE_IDLE;
                    ld_res[0] = mk_res(ACT_ERROR, 16'd0, 10'd0,
                                       (in_reg.pkt_opcode != OPC_DATA) ? WHY_UNEXPECT
                                                                       : WHY_BLK_NUM,
                                       CAUSE_NONE);
                    ld_res[1] = mk_res(ACT_ABORT, 16'd0, 10'd0, WHY_NONE, CAUSE_PROTO);
                end else begin
                    block_next   = blk_inc;
                    length_next  = plen_cl;
                    final_next   = ({1'b0, plen_cl} < BlockLen);
                    retries_next = budget;
                    ld_n         = 2'd2;
                    ld_res[0]    = mk_res(ACT_STORE, blk_inc, plen_cl, WHY_NONE, CAUSE_NONE);
                    ld_res[1]    = mk_res(ACT_ACK, blk_inc, 10'd0, WHY_NONE, CAUSE_NONE);
                    if (final_next) begin
                        ld_n      = 2'd3;
                        mode_next = MODE_IDLE;
                        ld_res[2] = mk_res(ACT_DONE, blk_inc, 10'd0, WHY_NONE, CAUSE_NONE);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            retry_limit_reg <= RETRY_LIMIT_RST;
            mode_reg        <= MODE_IDLE;
            block_reg       <= 16'd0;
            retries_reg     <= 4'd0;
            final_reg       <= 1'b0;
            length_reg      <= 10'd0;
            count_reg       <= 2'd0;
        end else begin
            if (cfg_wr_en) begin
                retry_limit_reg <= cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
                in_reg       <= req_t'(s_tdata[53:0]);
            end else if (load) begin
                in_valid_reg <= 1'b0;
            end
            if (load) begin
                mode_reg    <= mode_next;
                block_reg   <= block_next;
                retries_reg <= retries_next;
                final_reg   <= final_next;
                length_reg  <= length_next;
                count_reg   <= ld_n;
                queue_reg   <= ld_res;
            end else if (pop) begin
                count_reg    <= count_reg - 2'd1;
                queue_reg[0] <= queue_reg[1];
                queue_reg[1] <= queue_reg[2];
            end
        end
    end

    `TTE_ASSERT_NOW(a_empty_queue_takes, in_valid_reg && count_reg == 2'd0, s_tready, "stall with empty result queue")
    `TTE_ASSERT_NEXT(a_abort_to_idle, load && ld_n != 2'd0 && ld_res[ld_n - 2'd1].action == ACT_ABORT, mode_reg == MODE_IDLE, "abort did not return to idle")
    `TTE_ASSERT_NEXT(a_store_rearms, load && ld_res[0].action == ACT_STORE, retries_reg == budget && block_reg == $past(blk_inc), "store did not rearm retries")
    `TTE_ASSERT_NEXT(a_idle_timeout_quiet, load && mode_reg == MODE_IDLE && in_reg.op != EV_PACKET, count_reg == 2'd0 && mode_reg == MODE_IDLE, "idle event produced an action")

endmodule
`default_nettype wire
